/* rtl/gmtf_pkg.sv */
`timescale 1ns / 1ps

package gmtf_pkg;

  localparam int unsigned IdW    = 8;
  localparam int unsigned GroupW = 3;
  localparam int unsigned LookW  = 8;
  localparam int unsigned PosW   = 4;

  typedef enum logic [1:0] {
    MODE_QUERY = 2'd0,
    MODE_REG   = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef struct packed {
    logic              clear;
    logic              write;
    logic [GroupW-1:0] group;
  } cell_ctrl_t;

endpackage

/* rtl/grouped_move_to_front_id_list.sv */
`timescale 1ns / 1ps
// result: registered; an accepted transaction's result shows on the master side in the next cycle
// throughput: one transaction per cycle while the master side keeps tready high
// lookup and move-to-front shift both happen in the accept cycle across the cell row
// reset: asynchronous, active low; every list is emptied and the output register cleared
// no clearing pass is needed after reset

module grouped_move_to_front_id_list
  import gmtf_pkg::*;
#(
  parameter int unsigned GROUPS     = 4,
  parameter int unsigned SLOTS      = 8,
  parameter int unsigned EMPTY_CODE = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // ident[7:0], group[10:8], look_back[18:11], zero fill
  input  logic [1:0]  s_axis_tuser,  // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // present[0], position[4:1], recent[5], zero fill
  output logic        m_axis_tuser   // bad_group[0]
);

  logic [IdW-1:0]    ident;
  logic [GroupW-1:0] group;
  logic [LookW-1:0]  look_back;
  logic [1:0]        mode;
  logic              accept;
  logic              group_ok;
  cell_ctrl_t        ctrl;

  logic [IdW-1:0]    entry_chain [SLOTS+1];
  logic [SLOTS:0]    valid_chain;
  logic [SLOTS:0]    hit_chain;
  logic [SLOTS-1:0]  match;
  logic [PosW-1:0]   pos;

  logic              out_valid_q;
  logic              present_q, present_d;
  logic [PosW-1:0]   position_q, position_d;
  logic              recent_q, recent_d;
  logic              bad_q, bad_d;

  assign ident     = s_axis_tdata[IdW-1:0];
  assign group     = s_axis_tdata[IdW+GroupW-1:IdW];
  assign look_back = s_axis_tdata[IdW+GroupW+LookW-1:IdW+GroupW];
  assign mode      = s_axis_tuser;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign group_ok      = ({1'b0, group} < (GroupW + 1)'(GROUPS));

  assign ctrl.clear = accept && (mode == MODE_CLEAR);
  assign ctrl.write = accept && (mode == MODE_REG) && group_ok;
  assign ctrl.group = group;

  assign entry_chain[0] = ident;
  assign valid_chain[0] = 1'b1;
  assign hit_chain[0]   = 1'b0;

  for (genvar s = 0; s < SLOTS; s++) begin : g_cell
    gmtf_cell #(
      .GROUPS    (GROUPS),
      .EMPTY_CODE(EMPTY_CODE)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .ident_i     (ident),
      .hit_i       (hit_chain[s]),
      .hit_o       (hit_chain[s+1]),
      .match_o     (match[s]),
      .prev_entry_i(entry_chain[s]),
      .prev_valid_i(valid_chain[s]),
      .entry_o     (entry_chain[s+1]),
      .valid_o     (valid_chain[s+1])
    );
  end

  always_comb begin
    pos = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (match[s] && !hit_chain[s]) begin
        pos = pos | PosW'(s);
      end
    end
  end

  always_comb begin
    present_d  = 1'b0;
    position_d = '0;
    recent_d   = 1'b0;
    bad_d      = 1'b0;
    case (mode)
      MODE_QUERY, MODE_REG: begin
        if (!group_ok) begin
          bad_d = 1'b1;
        end else if (hit_chain[SLOTS]) begin
          present_d  = 1'b1;
          position_d = pos;
          recent_d   = (look_back > LookW'(pos));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      present_q   <= 1'b0;
      position_q  <= '0;
      recent_q    <= 1'b0;
      bad_q       <= 1'b0;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        present_q   <= present_d;
        position_q  <= position_d;
        recent_q    <= recent_d;
        bad_q       <= bad_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, recent_q, position_q, present_q};
  assign m_axis_tuser  = bad_q;

  a_ids_unique : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("identifier held in more than one slot of a list");

  a_bad_no_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == 8'd0))
    else $error("bad group result carries lookup data");

  a_recent_present : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[0])
    else $error("recent without present");

  a_clear_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode == MODE_CLEAR)
      |=> m_axis_tvalid && (m_axis_tdata == 8'd0) && !m_axis_tuser)
    else $error("clear transaction gave a nonzero result");

endmodule

/* rtl/gmtf_cell.sv */
`timescale 1ns / 1ps

module gmtf_cell
  import gmtf_pkg::*;
#(
  parameter int unsigned GROUPS     = 4,
  parameter int unsigned EMPTY_CODE = 31
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cell_ctrl_t     ctrl_i,
  input  logic [IdW-1:0] ident_i,
  input  logic           hit_i,
  output logic           hit_o,
  output logic           match_o,
  input  logic [IdW-1:0] prev_entry_i,
  input  logic           prev_valid_i,
  output logic [IdW-1:0] entry_o,
  output logic           valid_o
);

  localparam int unsigned GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam logic [IdW-1:0] EmptyVal = IdW'(EMPTY_CODE);

  logic [IdW-1:0]    entry_q [GROUPS];
  logic [GROUPS-1:0] valid_q;
  logic [GW-1:0]     sel;

  assign sel     = ctrl_i.group[GW-1:0];
  assign entry_o = entry_q[sel];
  assign valid_o = valid_q[sel];
  assign match_o = valid_o && (entry_o == ident_i);
  assign hit_o   = hit_i | match_o;

  // clear empties every group; a write shifts from the neighbor while no newer cell holds the identifier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int g = 0; g < GROUPS; g++) begin
        entry_q[g] <= EmptyVal;
      end
    end else if (ctrl_i.clear) begin
      valid_q <= '0;
      for (int g = 0; g < GROUPS; g++) begin
        entry_q[g] <= EmptyVal;
      end
    end else if (ctrl_i.write && !hit_i) begin
      entry_q[sel] <= prev_entry_i;
      valid_q[sel] <= prev_valid_i;
    end
  end

endmodule

/* tb/grouped_move_to_front_id_list_test.sv */
`timescale 1ns / 1ps

module grouped_move_to_front_id_list_test;
  import gmtf_pkg::*;

  localparam int GROUPS     = 4;
  localparam int SLOTS      = 8;
  localparam int EMPTY_CODE = 31;
  localparam int LONG_HOLD  = 60;

  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    logic       present;
    logic [3:0] position;
    logic       recent;
    logic       bad_group;
  } outcome_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  ident;
    logic [2:0]  group;
    logic [7:0]  look_back;
    logic        typed;
    outcome_t    want;
  } row_t;

  localparam outcome_t OUT_ZERO    = '{1'b0, 4'd0, 1'b0, 1'b0};
  localparam outcome_t OUT_BAD     = '{1'b0, 4'd0, 1'b0, 1'b1};
  localparam outcome_t OUT_TOP_OLD = '{1'b1, 4'd0, 1'b0, 1'b0};
  localparam outcome_t OUT_TOP_NEW = '{1'b1, 4'd0, 1'b1, 1'b0};

  localparam row_t DIRECTED [24] = '{
    '{MODE_QUERY, 8'd31,  3'd0, 8'd255, 1'b1, OUT_ZERO},
    '{MODE_QUERY, 8'd5,   3'd7, 8'd255, 1'b1, OUT_BAD},
    '{MODE_REG,   8'd5,   3'd4, 8'd1,   1'b1, OUT_BAD},
    '{MODE_NONE,  8'd255, 3'd7, 8'd255, 1'b1, OUT_ZERO},
    '{MODE_REG,   8'd0,   3'd0, 8'd0,   1'b1, OUT_ZERO},
    '{MODE_QUERY, 8'd0,   3'd0, 8'd0,   1'b1, OUT_TOP_OLD},
    '{MODE_QUERY, 8'd0,   3'd0, 8'd255, 1'b1, OUT_TOP_NEW},
    '{MODE_REG,   8'd255, 3'd0, 8'd1,   1'b0, OUT_ZERO},
    '{MODE_REG,   8'd31,  3'd0, 8'd2,   1'b0, OUT_ZERO},
    '{MODE_REG,   8'd1,   3'd0, 8'd3,   1'b0, OUT_ZERO},
    '{MODE_REG,   8'd2,   3'd0, 8'd3,   1'b0, OUT_ZERO},
    '{MODE_REG,   8'd3,   3'd0, 8'd3,   1'b0, OUT_ZERO},
    '{MODE_REG,   8'd4,   3'd0, 8'd3,   1'b0, OUT_ZERO},
    '{MODE_REG,   8'd5,   3'd0, 8'd3,   1'b0, OUT_ZERO},
    '{MODE_REG,   8'd6,   3'd0, 8'd3,   1'b0, OUT_ZERO},
    '{MODE_QUERY, 8'd0,   3'd0, 8'd255, 1'b0, OUT_ZERO},
    '{MODE_QUERY, 8'd255, 3'd0, 8'd7,   1'b0, OUT_ZERO},
    '{MODE_REG,   8'd255, 3'd0, 8'd8,   1'b0, OUT_ZERO},
    '{MODE_REG,   8'd200, 3'd3, 8'd128, 1'b0, OUT_ZERO},
    '{MODE_QUERY, 8'd200, 3'd1, 8'd255, 1'b0, OUT_ZERO},
    '{MODE_REG,   8'd200, 3'd3, 8'd0,   1'b0, OUT_ZERO},
    '{MODE_CLEAR, 8'd255, 3'd7, 8'd255, 1'b1, OUT_ZERO},
    '{MODE_QUERY, 8'd255, 3'd0, 8'd255, 1'b1, OUT_ZERO},
    '{MODE_QUERY, 8'd31,  3'd0, 8'd255, 1'b1, OUT_ZERO}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;

  logic [7:0]  recency_row [GROUPS][SLOTS];
  int          row_fill [GROUPS];
  outcome_t    pending_outcomes [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;
  int unsigned errors;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned hits_seen;
  int unsigned bad_seen;
  int unsigned clears_sent;

  grouped_move_to_front_id_list #(
    .GROUPS    (GROUPS),
    .SLOTS     (SLOTS),
    .EMPTY_CODE(EMPTY_CODE)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void wipe_rows();
    for (int g = 0; g < GROUPS; g++) begin
      for (int s = 0; s < SLOTS; s++) recency_row[g][s] = 8'(EMPTY_CODE);
      row_fill[g] = 0;
    end
  endfunction

  function automatic outcome_t predict_recency(input logic [1:0] m, input logic [7:0] id,
                                               input logic [2:0] g, input logic [7:0] lb);
    outcome_t o;
    int hit;
    int top;
    o = OUT_ZERO;
    hit = -1;
    if (m == MODE_CLEAR) begin
      wipe_rows();
    end else if (m == MODE_QUERY || m == MODE_REG) begin
      if (int'(g) >= GROUPS) begin
        o.bad_group = 1'b1;
      end else begin
        for (int s = SLOTS - 1; s >= 0; s--) begin
          if (s < row_fill[g] && recency_row[g][s] == id) hit = s;
        end
        if (hit >= 0) begin
          o.present = 1'b1;
          o.position = hit[3:0];
          o.recent = int'(lb) > hit;
        end
        if (m == MODE_REG) begin
          if (hit >= 0) begin
            top = hit;
          end else begin
            top = SLOTS - 1;
            if (row_fill[g] < SLOTS) row_fill[g]++;
          end
          for (int s = top; s > 0; s--) recency_row[g][s] = recency_row[g][s-1];
          recency_row[g][0] = id;
        end
      end
    end
    return o;
  endfunction

  function automatic void note_error(input string what, input outcome_t want,
                                     input outcome_t got);
    errors++;
    if (errors <= 10)
      $display("%t %s: want present=%0b pos=%0d recent=%0b bad=%0b, got present=%0b pos=%0d recent=%0b bad=%0b",
               $realtime, what, want.present, want.position, want.recent, want.bad_group,
               got.present, got.position, got.recent, got.bad_group);
  endfunction

  // call at a rising edge; leaves tvalid high at the accepting edge
  task automatic send_item(input logic [1:0] m, input logic [7:0] id, input logic [2:0] g,
                           input logic [7:0] lb, input logic typed, input outcome_t want);
    outcome_t o;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, lb, g, id};
    s_axis_tuser <= m;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    o = predict_recency(m, id, g, lb);
    pending_outcomes.push_back(typed ? want : o);
    items_sent++;
    hits_seen += o.present;
    bad_seen += o.bad_group;
    if (m == MODE_CLEAR) clears_sent++;
  endtask

  task automatic random_item();
    logic [1:0] m;
    logic [7:0] id;
    logic [2:0] g;
    logic [7:0] lb;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 46) m = MODE_REG;
    else if (pick < 93) m = MODE_QUERY;
    else if (pick < 96) m = MODE_CLEAR;
    else m = MODE_NONE;
    g = ($urandom_range(99) < 8) ? 3'($urandom_range(7)) : 3'($urandom_range(GROUPS - 1));
    if ($urandom_range(99) < 85) begin
      pick = $urandom_range(11);
      id = (pick == 11) ? 8'(EMPTY_CODE) : 8'(pick);
    end else begin
      id = 8'($urandom_range(255));
    end
    lb = ($urandom_range(99) < 75) ? 8'($urandom_range(SLOTS + 1)) : 8'($urandom_range(255));
    send_item(m, id, g, lb, 1'b0, OUT_ZERO);
  endtask

  // drain, then switch idling at a falling edge; returns at a rising edge
  task automatic settle(input int unsigned s_pct, input int unsigned r_pct, input bit hold);
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    hold_req = hold;
    @(posedge clk_i);
  endtask

  initial begin : drain_side
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    outcome_t got;
    outcome_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[0], m_axis_tdata[4:1], m_axis_tdata[5], m_axis_tuser};
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        note_error("unexpected transaction", OUT_ZERO, got);
      end else begin
        want = pending_outcomes.pop_front();
        if (got !== want) note_error("mismatch", want, got);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    send_idle_pct = 10;
    recv_idle_pct = 63;
    hold_req = 1'b0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    hits_seen = 0;
    bad_seen = 0;
    clears_sent = 0;
    wipe_rows();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i])
      send_item(DIRECTED[i].mode, DIRECTED[i].ident, DIRECTED[i].group,
                DIRECTED[i].look_back, DIRECTED[i].typed, DIRECTED[i].want);

    settle(10, 63, 1'b0);
    repeat (130) random_item();
    settle(63, 10, 1'b0);
    repeat (130) random_item();
    // long output stall while items keep coming
    settle(0, 0, 1'b1);
    repeat (140) random_item();

    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("checked %0d results for %0d transactions", results_seen, items_sent);
    $display("%0d hits, %0d bad-group, %0d clears", hits_seen, bad_seen, clears_sent);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* grouped_move_to_front_id_list.f */
rtl/gmtf_pkg.sv
rtl/gmtf_cell.sv
rtl/grouped_move_to_front_id_list.sv
tb/grouped_move_to_front_id_list_test.sv
